FILE: rtl/crcsfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// crcsfb_pkg
// Shared types, constants and the CRC byte update for the frame builder.
// ============================================================================
package crcsfb_pkg;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [31:0] SYNC_WORD_RESET      = 32'h314B_5345;
    localparam logic [7:0]  FORMAT_VERSION_RESET = 8'd1;
    localparam logic [15:0] FRAME_LENGTH_RESET   = 16'd1188;

    localparam int          APB_ADDR_W = 4;
    localparam int          APB_DATA_W = 32;
    localparam int          QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [1:0]  REG_SYNC_WORD      = 2'd0;
    localparam logic [1:0]  REG_FORMAT_VERSION = 2'd1;
    localparam logic [1:0]  REG_FRAME_LENGTH   = 2'd2;

    localparam logic [0:0]  KIND_START   = 1'b0;
    localparam logic [0:0]  KIND_PAYLOAD = 1'b1;

    localparam logic [1:0]  CMD_START   = 2'd0;
    localparam logic [1:0]  CMD_PAYLOAD = 2'd1;
    localparam logic [1:0]  CMD_MISUSE  = 2'd2;

    localparam logic [3:0]  HEADER_LAST_IDX  = 4'd15;
    localparam logic [3:0]  TRAILER_LAST_IDX = 4'd4;

    typedef struct packed {
        logic [0:0]  kind;
        logic [7:0]  frame_flags;
        logic [31:0] time_ms;
        logic [7:0]  payload_byte;
        logic [0:0]  payload_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [0:0] frame_end;
        logic [0:0] run_last;
        logic [0:0] misuse;
    } out_item_t;

    typedef struct packed {
        logic [31:0] sync_word;
        logic [7:0]  format_version;
        logic [15:0] frame_length;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  flags;
        logic [31:0] time_ms;
        logic [31:0] counter;
        logic [7:0]  pbyte;
        logic        plast;
    } cmd_entry_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/crcsfb_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// crcsfb_regs
// APB configuration registers: sync word, format version and frame length.
// ============================================================================
module crcsfb_regs
    import crcsfb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_word      <= SYNC_WORD_RESET;
            cfg_reg.format_version <= FORMAT_VERSION_RESET;
            cfg_reg.frame_length   <= FRAME_LENGTH_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SYNC_WORD:      cfg_reg.sync_word      <= pwdata;
                REG_FORMAT_VERSION: cfg_reg.format_version <= pwdata[7:0];
                REG_FRAME_LENGTH:   cfg_reg.frame_length   <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SYNC_WORD:      prdata = cfg_reg.sync_word;
            REG_FORMAT_VERSION: prdata = {24'd0, cfg_reg.format_version};
            REG_FRAME_LENGTH:   prdata = {16'd0, cfg_reg.frame_length};
            default:            prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/crcsfb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// crcsfb_front
// Accepts items, tracks the open frame and the frame counter, and turns each
// item into a command for the byte serializer.
// ============================================================================
module crcsfb_front
    import crcsfb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire in_item_t item,
    input  wire logic     q_full,
    output logic          full,
    output logic          q_push,
    output cmd_entry_t    q_entry
);

    logic        frame_open_reg;
    logic        frame_open_next;
    logic [31:0] counter_reg;
    logic [31:0] counter_next;

    assign full   = q_full;
    assign q_push = push && !q_full;

    always_comb
    begin
        frame_open_next = frame_open_reg;
        counter_next    = counter_reg;
        q_entry.flags   = item.frame_flags;
        q_entry.time_ms = item.time_ms;
        q_entry.counter = counter_reg;
        q_entry.pbyte   = item.payload_byte;
        q_entry.plast   = item.payload_last;
        if (item.kind == KIND_START)
        begin
            q_entry.cmd     = CMD_START;
            frame_open_next = 1'b1;
            counter_next    = counter_reg + 32'd1;
        end
        else if (!frame_open_reg)
        begin
            q_entry.cmd = CMD_MISUSE;
        end
        else
        begin
            q_entry.cmd = CMD_PAYLOAD;
            if (item.payload_last)
            begin
                frame_open_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            counter_reg    <= '0;
        end
        else if (q_push)
        begin
            frame_open_reg <= frame_open_next;
            counter_reg    <= counter_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/crcsfb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// crcsfb_queue
// Short command queue between the front end and the byte serializer.
// ============================================================================
module crcsfb_queue
    import crcsfb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire cmd_entry_t wr_data,
    input  wire logic       rd_en,
    output cmd_entry_t      rd_data,
    output logic            full,
    output logic            empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_entry_t    entries_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/crcsfb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// crcsfb_back
// Byte serializer: expands each command into header, payload and trailer
// bytes, updates the running CRC and holds the result in an output register.
// ============================================================================
module crcsfb_back
    import crcsfb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire cmd_entry_t head,
    input  wire logic       head_empty,
    output logic            head_pop,
    input  wire logic       pop,
    output logic            empty,
    output out_item_t       result
);

    logic [3:0]   idx_reg;
    logic [31:0]  crc_reg;
    logic [31:0]  crc_next;
    logic         out_valid_reg;
    out_item_t    out_reg;
    out_item_t    out_next;
    logic         advance;
    logic [3:0]   last_idx;
    logic         item_done;
    logic [127:0] hdr;
    logic [31:0]  fin;
    logic [1:0]   tidx;

    assign empty   = !out_valid_reg;
    assign result  = out_reg;
    assign advance = !head_empty && (!out_valid_reg || pop);

    assign hdr  = {head.time_ms, head.counter, cfg.frame_length, head.flags,
                   cfg.format_version, cfg.sync_word};
    assign fin  = ~crc_reg;
    assign tidx = idx_reg[1:0] - 2'd1;

    always_comb
    begin
        case (head.cmd)
            CMD_START:   last_idx = HEADER_LAST_IDX;
            CMD_PAYLOAD: last_idx = head.plast ? TRAILER_LAST_IDX : 4'd0;
            default:     last_idx = 4'd0;
        endcase
    end

    assign item_done = (idx_reg == last_idx);
    assign head_pop  = advance && item_done;

    always_comb
    begin
        out_next.frame_end = 1'b0;
        out_next.run_last  = item_done;
        out_next.misuse    = 1'b0;
        crc_next           = crc_reg;
        case (head.cmd)
            CMD_START:
            begin
                out_next.out_byte = hdr[{idx_reg, 3'b000} +: 8];
                crc_next = crc_byte((idx_reg == 4'd0) ? CRC_ALL_ONES : crc_reg,
                                    out_next.out_byte);
            end
            CMD_PAYLOAD:
            begin
                if (idx_reg == 4'd0)
                begin
                    out_next.out_byte = head.pbyte;
                    crc_next          = crc_byte(crc_reg, head.pbyte);
                end
                else
                begin
                    out_next.out_byte = fin[{tidx, 3'b000} +: 8];
                    if (item_done)
                    begin
                        out_next.frame_end = 1'b1;
                        crc_next           = CRC_ALL_ONES;
                    end
                end
            end
            default:
            begin
                out_next.out_byte = 8'd0;
                out_next.misuse   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            crc_reg       <= CRC_ALL_ONES;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            idx_reg       <= item_done ? 4'd0 : idx_reg + 4'd1;
            crc_reg       <= crc_next;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/crc32_sensor_frame_builder.sv
// An accepted item is written into the command queue, and the serializer then registers
// its first result byte. Throughput: one result byte per cycle while a command is queued
// and the result is empty or popped; a start item yields 16 bytes, a last payload byte 5,
// other payload bytes 1; the queue holds QUEUE_DEPTH items, so items are taken back to back
// until it is full, also while the serializer is busy. Reset: frame counter 0, running CRC
// all ones, no open frame, queue and output register empty, registers at their reset values.
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// crc32_sensor_frame_builder
// Framed sensor packet builder with a reflected CRC-32 trailer.
// ============================================================================
module crc32_sensor_frame_builder
    import crcsfb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  push,
    output logic                       full,
    input  wire in_item_t              item,
    output logic                       empty,
    input  wire logic                  pop,
    output out_item_t                  result
);

    cfg_t       cfg;
    logic       q_push;
    cmd_entry_t q_entry;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    cmd_entry_t q_head;

    crcsfb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crcsfb_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .q_full  (q_full),
        .full    (full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    crcsfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_entry),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    crcsfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head       (q_head),
        .head_empty (q_empty),
        .head_pop   (q_pop),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule
`default_nettype wire
